// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/rrp_pkg.sv -----
// Shared types, limits and codes of the RESP request parser.
`timescale 1ns / 1ps
package rrp_pkg;

   localparam int unsigned MaxArgs    = 256;
   localparam int unsigned MaxBulkLen = 1048576;

   localparam int unsigned AccW  = 21;
   localparam int unsigned ArgsW = $clog2(MaxArgs + 1);
   localparam int unsigned PosW  = 24;

   localparam int unsigned FifoDepth = 4;
   localparam int unsigned FifoAw    = $clog2(FifoDepth);

   localparam logic [AccW-1:0] ArgsLimit = AccW'(MaxArgs);
   localparam logic [AccW-1:0] BulkLimit = AccW'(MaxBulkLen);

   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChMinus  = 8'h2D;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;

   // Result event codes
   localparam logic [1:0] EvFraming  = 2'd0;
   localparam logic [1:0] EvPayload  = 2'd1;
   localparam logic [1:0] EvComplete = 2'd2;
   localparam logic [1:0] EvError    = 2'd3;

   // Error kinds
   localparam logic [2:0] ErrNone      = 3'd0;
   localparam logic [2:0] ErrNoArray   = 3'd1;
   localparam logic [2:0] ErrCount     = 3'd2;
   localparam logic [2:0] ErrNoBulk    = 3'd3;
   localparam logic [2:0] ErrLength    = 3'd4;
   localparam logic [2:0] ErrTruncated = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [1:0]      event_res;
      logic [7:0]      payload_byte;
      logic [7:0]      arg_number;
      logic            arg_first;
      logic            arg_last;
      logic [AccW-1:0] arg_size;
      logic [2:0]      error_kind;
      logic [PosW-1:0] bytes_consumed;
   } rsp_type;

   // Byte with its character class, decoded in the front stage
   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_star;
      logic       is_dollar;
      logic       is_minus;
      logic       is_cr;
      logic       is_lf;
   } class_type;

   typedef struct packed {
      logic full;
      logic valid;
   } fifo_stat_type;

endpackage

// ----- rtl/rrp_front.sv -----
// Front stage: accept request beats and decode their character class.
`timescale 1ns / 1ps
module rrp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rrp_pkg::req_type      req_data,
   input  rrp_pkg::fifo_stat_type fifo_stat,
   output logic                  item_valid,
   output rrp_pkg::class_type    item_data
);
   import rrp_pkg::*;

   logic      front_valid_ff, front_valid_in;
   class_type front_item_ff, front_item_in;

   // Hold the stage while the queue is full
   assign req_stall = front_valid_ff & fifo_stat.full;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (!req_stall) begin
         front_valid_in = req_valid;
      end

      front_item_in            = '0;
      front_item_in.data_byte  = req_data.data_byte;
      front_item_in.buffer_end = req_data.buffer_end;
      front_item_in.is_digit   = req_data.data_byte inside {[ChZero:ChNine]};
      front_item_in.digit      = 4'(req_data.data_byte - ChZero);
      front_item_in.is_star    = req_data.data_byte == ChStar;
      front_item_in.is_dollar  = req_data.data_byte == ChDollar;
      front_item_in.is_minus   = req_data.data_byte == ChMinus;
      front_item_in.is_cr      = req_data.data_byte == ChCr;
      front_item_in.is_lf      = req_data.data_byte == ChLf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (req_valid && !req_stall) begin
         front_item_ff <= front_item_in;
      end
   end

   assign item_valid = front_valid_ff;
   assign item_data  = front_item_ff;

endmodule

// ----- rtl/rrp_fifo.sv -----
// Short queue of classified bytes between the front and back stages.
`timescale 1ns / 1ps
module rrp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  rrp_pkg::class_type     push_data,
   input  logic                   pop,
   output rrp_pkg::fifo_stat_type fifo_stat,
   output rrp_pkg::class_type     head_data
);
   import rrp_pkg::*;

   class_type          entry_ff [FifoDepth];
   logic [FifoAw-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FifoAw-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FifoAw:0]    count_ff, count_in;
   logic               push;
   logic               pop_ok;

   assign fifo_stat.full  = count_ff == (FifoAw + 1)'(FifoDepth);
   assign fifo_stat.valid = count_ff != '0;
   assign push            = push_valid & ~fifo_stat.full;
   assign pop_ok          = pop & fifo_stat.valid;
   assign head_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/rrp_back.sv -----
// Back stage: RESP parse state machine and the registered result beat.
`timescale 1ns / 1ps
module rrp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  rrp_pkg::class_type item_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rrp_pkg::rsp_type   rsp_data
);
   import rrp_pkg::*;

   typedef enum logic [11:0] {
      PhStar    = 12'b0000_0000_0001,
      PhCntSign = 12'b0000_0000_0010,
      PhCntDig  = 12'b0000_0000_0100,
      PhCntLf   = 12'b0000_0000_1000,
      PhDollar  = 12'b0000_0001_0000,
      PhLenSign = 12'b0000_0010_0000,
      PhLenDig  = 12'b0000_0100_0000,
      PhLenLf   = 12'b0000_1000_0000,
      PhPayload = 12'b0001_0000_0000,
      PhTerm1   = 12'b0010_0000_0000,
      PhTerm2   = 12'b0100_0000_0000,
      PhDrain   = 12'b1000_0000_0000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [AccW-1:0]  acc_ff, acc_in;
   logic             minus_ff, minus_in;
   logic [ArgsW-1:0] args_ff, args_in;
   logic [AccW-1:0]  left_ff, left_in;
   logic [7:0]       cur_ff, cur_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_in;

   logic             out_free;
   logic [AccW+3:0]  acc_x10;
   logic [AccW-1:0]  acc_dig;
   logic [PosW-1:0]  pos_inc;
   logic             neg_bad;
   logic [ArgsW-1:0] args_dec;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = item_valid & out_free;

   // Multiply by ten as two shifts, add the digit, then saturate
   assign acc_x10 = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + (AccW + 4)'(item_data.digit);
   assign acc_dig = (acc_x10[AccW+3:AccW] != '0) ? '1 : acc_x10[AccW-1:0];
   assign pos_inc = (pos_ff != '1) ? pos_ff + 1'b1 : pos_ff;
   assign neg_bad = minus_ff & (acc_ff != '0);
   assign args_dec = (args_ff != '0) ? args_ff - 1'b1 : '0;

   always_comb begin
      logic       err_hit;
      logic [2:0] err_code;
      logic [AccW-1:0] len_val;

      err_hit  = 1'b0;
      err_code = ErrNone;
      len_val  = '0;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      minus_in = minus_ff;
      args_in  = args_ff;
      left_in  = left_ff;
      cur_in   = cur_ff;
      pos_in   = pos_inc;
      rsp_in   = '0;

      case (phase_ff)
         PhStar: begin
            if (!item_data.is_star) begin
               err_hit  = 1'b1;
               err_code = ErrNoArray;
            end else if (item_data.buffer_end) begin
               err_hit  = 1'b1;
               err_code = ErrCount;
            end else begin
               acc_in   = '0;
               minus_in = 1'b0;
               phase_in = PhCntSign;
            end
         end
         PhCntSign, PhCntDig: begin
            if (phase_ff == PhCntSign && item_data.is_minus) begin
               minus_in = 1'b1;
               phase_in = PhCntDig;
            end else begin
               phase_in = PhCntDig;
               if (item_data.is_digit) begin
                  acc_in = acc_dig;
               end else if (item_data.is_cr) begin
                  phase_in = PhCntLf;
               end else begin
                  err_hit  = 1'b1;
                  err_code = ErrCount;
               end
            end
            if (item_data.buffer_end) begin
               err_hit  = 1'b1;
               err_code = ErrCount;
            end
         end
         PhCntLf: begin
            if (!item_data.is_lf || neg_bad || acc_ff > ArgsLimit) begin
               err_hit  = 1'b1;
               err_code = ErrCount;
            end else begin
               args_in = minus_ff ? '0 : acc_ff[ArgsW-1:0];
               cur_in  = '0;
               if (minus_ff || acc_ff == '0) begin
                  rsp_in.event_res      = EvComplete;
                  rsp_in.bytes_consumed = pos_inc;
                  pos_in   = '0;
                  phase_in = PhStar;
               end else if (item_data.buffer_end) begin
                  err_hit  = 1'b1;
                  err_code = ErrNoBulk;
               end else begin
                  phase_in = PhDollar;
               end
            end
         end
         PhDollar: begin
            if (!item_data.is_dollar) begin
               err_hit  = 1'b1;
               err_code = ErrNoBulk;
            end else if (item_data.buffer_end) begin
               err_hit  = 1'b1;
               err_code = ErrLength;
            end else begin
               acc_in   = '0;
               minus_in = 1'b0;
               phase_in = PhLenSign;
            end
         end
         PhLenSign, PhLenDig: begin
            if (phase_ff == PhLenSign && item_data.is_minus) begin
               minus_in = 1'b1;
               phase_in = PhLenDig;
            end else begin
               phase_in = PhLenDig;
               if (item_data.is_digit) begin
                  acc_in = acc_dig;
               end else if (item_data.is_cr) begin
                  phase_in = PhLenLf;
               end else begin
                  err_hit  = 1'b1;
                  err_code = ErrLength;
               end
            end
            if (item_data.buffer_end) begin
               err_hit  = 1'b1;
               err_code = ErrLength;
            end
         end
         PhLenLf: begin
            if (!item_data.is_lf || neg_bad || acc_ff > BulkLimit) begin
               err_hit  = 1'b1;
               err_code = ErrLength;
            end else begin
               len_val = minus_ff ? '0 : acc_ff;
               acc_in  = len_val;
               left_in = len_val;
               if (item_data.buffer_end) begin
                  err_hit  = 1'b1;
                  err_code = ErrTruncated;
               end else begin
                  phase_in = (len_val != '0) ? PhPayload : PhTerm1;
               end
            end
         end
         PhPayload: begin
            if (item_data.buffer_end) begin
               err_hit  = 1'b1;
               err_code = ErrTruncated;
            end else begin
               rsp_in.event_res    = EvPayload;
               rsp_in.payload_byte = item_data.data_byte;
               rsp_in.arg_number   = cur_ff;
               rsp_in.arg_first    = left_ff == acc_ff;
               rsp_in.arg_last     = left_ff == AccW'(1);
               rsp_in.arg_size     = acc_ff;
               left_in = left_ff - 1'b1;
               if (left_ff == AccW'(1)) begin
                  phase_in = PhTerm1;
               end
            end
         end
         PhTerm1: begin
            if (item_data.buffer_end) begin
               err_hit  = 1'b1;
               err_code = ErrTruncated;
            end else begin
               phase_in = PhTerm2;
            end
         end
         PhTerm2: begin
            args_in = args_dec;
            cur_in  = cur_ff + 1'b1;
            if (args_dec == '0) begin
               rsp_in.event_res      = EvComplete;
               rsp_in.bytes_consumed = pos_inc;
               pos_in   = '0;
               phase_in = PhStar;
            end else if (item_data.buffer_end) begin
               err_hit  = 1'b1;
               err_code = ErrNoBulk;
            end else begin
               phase_in = PhDollar;
            end
         end
         PhDrain: begin
            // Drop bytes up to the buffer end without counting them
            pos_in = pos_ff;
            if (item_data.buffer_end) begin
               phase_in = PhStar;
            end
         end
         default: begin
            phase_in = PhStar;
            acc_in   = '0;
            minus_in = 1'b0;
            args_in  = '0;
            left_in  = '0;
            cur_in   = '0;
            pos_in   = '0;
         end
      endcase

      if (err_hit) begin
         rsp_in            = '0;
         rsp_in.event_res  = EvError;
         rsp_in.error_kind = err_code;
         phase_in = item_data.buffer_end ? PhStar : PhDrain;
         pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhStar;
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         args_ff      <= '0;
         left_ff      <= '0;
         cur_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff     <= phase_in;
            acc_ff       <= acc_in;
            minus_ff     <= minus_in;
            args_ff      <= args_in;
            left_ff      <= left_in;
            cur_ff       <= cur_in;
            pos_ff       <= pos_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/resp_request_parser.sv -----
// Top level of the RESP array-of-bulk-strings request parser.
// Path: a byte is registered in the front stage, the queue, then the result beat.
// Throughput: one byte per cycle while no stall holds it; the back-stage parse
// step is the only recurrence, a combinational step with a shift-add multiply by ten.
// Reset: synchronous, active high; clears the queue, the parse state
// (back to expecting the array mark) and the result valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module resp_request_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rrp_pkg::rsp_type rsp_data
);
   import rrp_pkg::*;

   // Front stage to queue: one classified byte per beat
   logic          front_valid;
   class_type     front_item;
   fifo_stat_type fifo_stat;

   // Queue head to back stage
   class_type     head_item;
   logic          back_pop;

   // Decode the character class of each byte and register it. The front
   // stage stalls only while the queue is full, so a stalled result beat
   // still lets bytes fill the queue before backpressure reaches the request side.
   rrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .fifo_stat  (fifo_stat),
      .item_valid (front_valid),
      .item_data  (front_item)
   );

   // Decouple the front from the back; push and pop may occur together.
   rrp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_item),
      .pop        (back_pop),
      .fifo_stat  (fifo_stat),
      .head_data  (head_item)
   );

   // Advance the parse state once per byte and register the result beat.
   // A new byte is taken whenever the result register is empty or is being
   // drained in the same cycle.
   rrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (fifo_stat.valid),
      .item_data  (head_item),
      .pop        (back_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // An error beat always names its kind
   `ASSERT_IMPLY(a_err_has_kind, clock, reset, rsp_valid && rsp_data.event_res == EvError, rsp_data.error_kind != ErrNone, "error beat without error kind")

   // Argument marks only travel with payload beats
   `ASSERT_IMPLY(a_marks_on_payload, clock, reset, rsp_valid && (rsp_data.arg_first || rsp_data.arg_last), rsp_data.event_res == EvPayload, "argument mark on a non-payload beat")

   // A completed command has consumed at least its framing bytes
   `ASSERT_IMPLY(a_complete_count, clock, reset, rsp_valid && rsp_data.event_res == EvComplete, rsp_data.bytes_consumed != '0, "command complete with zero bytes consumed")

endmodule
